// ===== rtl/sorted_list_insert_delete_top_macros.svh =====
`ifndef SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sli_pkg.sv =====
package sli_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int STAT_W = 3;
  localparam int CNT_FIELD_W = 5;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // broadcast from control to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ===== rtl/sorted_list_insert_delete_top.sv =====
// Sorted multiset of up to DEPTH signed 32-bit values held in a row of
// compare/shift cells. Each beat inserts its value (tuser 0) or deletes one
// equal entry (tuser 1) and returns one result beat with status, entry count
// and smallest value. Every cell compares against the broadcast value and
// shifts toward its neighbor in the same cycle, so the store updates at the
// edge that accepts the beat and the result beat is valid from the next cycle.
// A new beat is taken every cycle while the output side keeps taking results;
// the result register frees up whenever the output side takes its beat.
// No clearing pass after reset.
module sorted_list_insert_delete_top
  import sli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [2:0] status, [7:3] count, [39:8] smallest
);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic signed [VAL_W-1:0] entry [DEPTH];
  logic signed [VAL_W-1:0] entry_nxt [DEPTH];
  cell_flags_t             flags [DEPTH];
  logic [DEPTH-1:0]        lt_v;
  logic [DEPTH-1:0]        eq_v;
  cell_cmd_t               cmd;
  logic                    accept;
  logic                    full;
  logic                    found;
  status_t                 status_c;
  logic signed [VAL_W-1:0] smallest_c;

  status_t                 status;
  logic [CNT_FIELD_W-1:0]  count_out;
  logic signed [VAL_W-1:0] smallest;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                    occ;
      logic                    blt;
      logic signed [VAL_W-1:0] bent;
      logic signed [VAL_W-1:0] aent;

      assign occ = count > CNT_W'(i);
      if (i == 0) begin : g_first
        assign blt  = 1'b1;
        assign bent = cmd.value;
      end else begin : g_mid
        assign blt  = lt_v[i-1];
        assign bent = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign aent = entry[i];
      end else begin : g_up
        assign aent = entry[i+1];
      end

      sli_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (occ),
        .below_lt    (blt),
        .below_entry (bent),
        .above_entry (aent),
        .entry       (entry[i]),
        .entry_next  (entry_nxt[i]),
        .flags       (flags[i])
      );

      assign lt_v[i] = flags[i].lt;
      assign eq_v[i] = flags[i].eq;
    end
  endgenerate

  assign full  = count == CNT_W'(DEPTH);
  assign found = |eq_v;

  always_comb begin
    cmd.value = s_tdata;
    cmd.ins   = accept && !s_tuser[0] && !full;
    cmd.del   = accept && s_tuser[0] && found;
  end

  always_comb begin
    if (!s_tuser[0]) begin
      status_c = full ? ST_FULL : ST_INSERTED;
    end else if (count == '0) begin
      status_c = ST_EMPTY;
    end else begin
      status_c = found ? ST_DELETED : ST_NOT_FOUND;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.del) begin
      count_next = count - 1'b1;
    end
  end

  assign smallest_c = (count_next == '0) ? '0 : entry_nxt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_c;
      count_out <= CNT_FIELD_W'(count_next);
      smallest  <= smallest_c;
    end
  end

  assign m_tdata = {smallest, count_out, status};

`include "sorted_list_insert_delete_top_macros.svh"

  `SLI_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "entry count above depth")
  `SLI_ASSERT_NEXT(a_ins_count, cmd.ins, count == CNT_W'($past(count) + 1'b1), "insert count")
  `SLI_ASSERT_NEXT(a_result_after_beat, accept, m_tvalid, "no result after accepted beat")
  `SLI_ASSERT_NOW(a_sorted_head, count >= CNT_W'(2), entry[0] <= entry[1], "head out of order")
  `SLI_ASSERT_NOW(a_full_status, m_tvalid && status == ST_FULL,
    count_out == CNT_FIELD_W'(DEPTH), "full status with short count")

endmodule

// ===== rtl/sli_cell.sv =====
module sli_cell
  import sli_pkg::*;
(
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic                    occ,          // cell index below entry count
  input  logic                    below_lt,     // lower neighbor holds a smaller value
  input  logic signed [VAL_W-1:0] below_entry,
  input  logic signed [VAL_W-1:0] above_entry,
  output logic signed [VAL_W-1:0] entry,
  output logic signed [VAL_W-1:0] entry_next,
  output cell_flags_t             flags
);

  assign flags.lt = occ && (entry < cmd.value);
  assign flags.eq = occ && (entry == cmd.value);

  // insert: cells at or above the slot shift up, the slot takes the value
  // delete: cells at or above the first match shift down
  always_comb begin
    entry_next = entry;
    if (cmd.ins && !flags.lt) begin
      entry_next = below_lt ? cmd.value : below_entry;
    end else if (cmd.del && !flags.lt) begin
      entry_next = above_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== tb/sv/sorted_store_checker_pkg.sv =====
package sorted_store_checker_pkg;
  import sli_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    status_t                 status;
    logic [CNT_FIELD_W-1:0]  count;
    logic signed [VAL_W-1:0] smallest;
  } store_reply_t;

  class sorted_store_checker;
    logic signed [VAL_W-1:0] held[$];   // shadow of the store, ascending
    store_reply_t expected_replies[$];
    int unsigned failures;
    int unsigned reported;

    function int pending();
      return expected_replies.size();
    endfunction

    // update the shadow store for one accepted beat and queue its reply
    function void apply_op(logic op, logic signed [VAL_W-1:0] v);
      store_reply_t r;
      int pos;
      pos = 0;
      if (op == OP_INSERT) begin
        if (held.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held.size() && held[pos] < v) pos++;
          held.insert(pos, v);
          r.status = ST_INSERTED;
        end
      end else if (held.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        while (pos < held.size() && held[pos] != v) pos++;
        if (pos == held.size()) begin
          r.status = ST_NOT_FOUND;
        end else begin
          held.delete(pos);
          r.status = ST_DELETED;
        end
      end
      r.count = CNT_FIELD_W'(held.size());
      r.smallest = (held.size() > 0) ? held[0] : '0;
      expected_replies.push_back(r);
    endfunction

    function void note_failure(string field, longint exp_v, longint got_v);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
      end
    endfunction

    function void check_reply(logic [39:0] beat);
      store_reply_t r;
      logic signed [VAL_W-1:0] got_min;
      if (expected_replies.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("result beat %h arrived with nothing outstanding", beat);
        end
        return;
      end
      r = expected_replies.pop_front();
      got_min = beat[39:8];
      if (beat[2:0] != r.status) note_failure("status", r.status, beat[2:0]);
      if (beat[7:3] != r.count) note_failure("count", r.count, beat[7:3]);
      if (got_min != r.smallest) note_failure("smallest", r.smallest, got_min);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_sorted_list_insert_delete_top.sv =====
module tb_sorted_list_insert_delete_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sli_pkg::*;
  import sorted_store_checker_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 880;

  typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_STALLS} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  sorted_store_checker chk = new();

  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_stall_left = 0;
  logic [7:0] rx_pattern = 8'b1011_0010;

  sorted_list_insert_delete_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // input side first so a same-cycle reply would still find its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) chk.apply_op(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) chk.check_reply(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver backpressure: switches between a few stall styles
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(30, 150);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      RX_PATTERN: begin
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        m_tready <= rx_pattern[0];
      end
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall_left = $urandom_range(3, 15);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input logic op, input logic signed [31:0] v);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (chk.pending() > 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] any_value();
    case ($urandom_range(0, 6))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(0, 15) - 8;
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  initial begin
    int ins_pct;
    logic op;
    logic signed [31:0] v;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(OP_DELETE, 32'sd0);           // delete on empty store
    send_beat(OP_INSERT, 32'sd5);
    send_beat(OP_DELETE, 32'sd5);           // back to empty, smallest reads 0
    send_beat(OP_INSERT, 32'sh80000000);
    send_beat(OP_INSERT, 32'sh7fffffff);
    send_beat(OP_INSERT, 32'sd0);
    send_beat(OP_INSERT, -32'sd1);
    send_beat(OP_INSERT, 32'sd0);           // duplicate
    send_beat(OP_DELETE, 32'sd7);           // absent value
    send_beat(OP_DELETE, 32'sd0);
    send_beat(OP_DELETE, 32'sh80000000);    // smallest moves up
    send_beat(OP_DELETE, 32'sh7fffffff);
    for (int k = 0; k < DEPTH - 2; k++) begin
      send_beat(OP_INSERT, (k % 2) ? -k * 100003 : k * 77777);
    end
    send_beat(OP_INSERT, 32'sd42);          // store full, rejected

    ins_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // alternate fill-heavy and drain-heavy phases to keep hitting both ends
      if (i % 40 == 0) ins_pct = ($urandom_range(0, 2) == 0) ? 50
                                : ((ins_pct > 50) ? 25 : 80);
      if (i == RANDOM_ITEMS / 2) drain_replies();
      op = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_DELETE;
      if (op == OP_DELETE && chk.held.size() > 0 && $urandom_range(0, 9) < 7) begin
        v = chk.held[$urandom_range(0, chk.held.size() - 1)];
      end else begin
        v = any_value();
      end
      send_beat(op, v);
    end

    drain_replies();
    repeat (8) @(posedge clk);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete_top.sv
tb/sv/sorted_store_checker_pkg.sv
tb/sv/tb_sorted_list_insert_delete_top.sv
